@@ src/cse_pkg.sv @@
package cse_pkg;

  localparam int VALUE_BITS  = 10;
  localparam int COUNT_BITS  = 16;
  localparam int TOTAL_BITS  = 26;
  localparam int NUM_BUCKETS = 1 << VALUE_BITS;
  localparam int BUCKET_BITS = $clog2(NUM_BUCKETS);

  localparam logic [VALUE_BITS-1:0] MAX_VALUE_RESET = '1;
  localparam logic [VALUE_BITS-1:0] SCAN_RESET      = VALUE_BITS'(1);

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_SCAN
  } state_t;

endpackage

@@ src/counting_sort_engine.sv @@
// Counting-sort engine built on a histogram of per-key bucket counts.
// Input channel (in_valid / in_stall, in_req_type, in_value): one beat is
// one request. An insert adds one to the bucket of in_value when the key is
// between 1 and the programmed max_value and the bucket is not saturated;
// otherwise it is rejected. A pop returns the smallest held key.
// Result channel (out_valid / out_stall, out_value_out, out_status): exactly
// one beat per request, in request order, held in an output register.
// Configuration channel (cfg_valid / cfg_ready, cfg_max_value) writes the
// max_value register; it is always ready and may be written only while idle.
// Flow: an insert first reads its bucket from the count RAM on acceptance,
// then checks and writes it back, and only then can the next request be
// taken. A pop reads one bucket per cycle from the scan position upward,
// skipping empty buckets, until it finds a held key. A pop with nothing
// held answers in the cycle after acceptance. Each step is paced by the
// single registered read port of the count RAM. A new request is taken only
// while the engine is idle and the output register is empty or draining,
// so a stalled receiver holds the result beat and in turn stalls the input.
// After reset the engine sweeps every bucket of the count RAM to zero, one
// bucket per cycle, with in_stall high; configuration writes are still taken.
module counting_sort_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [cse_pkg::VALUE_BITS-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cse_pkg::VALUE_BITS-1:0] out_value_out,
  output logic [1:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cse_pkg::VALUE_BITS-1:0] cfg_max_value
);

  cse_pkg::state_t state_r, state_nxt;

  logic [cse_pkg::BUCKET_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [cse_pkg::VALUE_BITS-1:0]  key_r, key_nxt;
  logic [cse_pkg::BUCKET_BITS-1:0] pos_r, pos_nxt;
  logic [cse_pkg::VALUE_BITS-1:0]  scan_pos_r, scan_pos_nxt;
  logic [cse_pkg::TOTAL_BITS-1:0]  held_r, held_nxt;
  logic [cse_pkg::VALUE_BITS-1:0]  max_value_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [cse_pkg::VALUE_BITS-1:0] out_value_r, out_value_nxt;
  cse_pkg::status_t               out_status_r, out_status_nxt;

  logic                            ram_we;
  logic [cse_pkg::BUCKET_BITS-1:0] ram_waddr;
  logic [cse_pkg::COUNT_BITS-1:0]  ram_wdata;
  logic [cse_pkg::BUCKET_BITS-1:0] ram_raddr;
  logic [cse_pkg::COUNT_BITS-1:0]  ram_rdata;

  logic in_accept;
  logic out_free;
  logic ins_reject;

  cse_count_ram #(
    .DEPTH(cse_pkg::NUM_BUCKETS),
    .WIDTH(cse_pkg::COUNT_BITS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;

  // The output register is free when empty or when its beat leaves this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == cse_pkg::S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;

  // Key zero, a key above max_value and a saturated bucket are all rejected.
  assign ins_reject = (key_r == '0) || (key_r > max_value_r) || (ram_rdata == '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cse_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      scan_pos_r  <= cse_pkg::SCAN_RESET;
      held_r      <= '0;
      max_value_r <= cse_pkg::MAX_VALUE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      scan_pos_r  <= scan_pos_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_value_r <= cfg_max_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    scan_pos_nxt   = scan_pos_r;
    held_nxt       = held_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = ram_rdata - cse_pkg::COUNT_BITS'(1);
    ram_raddr      = in_value;

    case (state_r)
      cse_pkg::S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + cse_pkg::BUCKET_BITS'(1);
        if (clr_addr_r == '1) begin
          state_nxt = cse_pkg::S_IDLE;
        end
      end

      cse_pkg::S_IDLE: begin
        if (in_accept) begin
          if (in_req_type == cse_pkg::REQ_INSERT) begin
            key_nxt   = in_value;
            ram_raddr = in_value;
            state_nxt = cse_pkg::S_INS;
          end else if (held_r == '0) begin
            // Nothing held: answer at once and leave the state alone.
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = cse_pkg::ST_EMPTY;
          end else begin
            ram_raddr = scan_pos_r;
            pos_nxt   = scan_pos_r;
            state_nxt = cse_pkg::S_SCAN;
          end
        end
      end

      cse_pkg::S_INS: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = key_r;
        state_nxt     = cse_pkg::S_IDLE;
        if (ins_reject) begin
          out_status_nxt = cse_pkg::ST_REJECTED;
        end else begin
          out_status_nxt = cse_pkg::ST_INSERTED;
          ram_we         = 1'b1;
          ram_waddr      = key_r;
          ram_wdata      = ram_rdata + cse_pkg::COUNT_BITS'(1);
          held_nxt       = held_r + cse_pkg::TOTAL_BITS'(1);
          if (key_r < scan_pos_r) begin
            scan_pos_nxt = key_r;
          end
        end
      end

      cse_pkg::S_SCAN: begin
        // The read for the next bucket is always issued; it is simply
        // discarded when the current bucket turns out to be the hit.
        ram_raddr = pos_r + cse_pkg::BUCKET_BITS'(1);
        if (ram_rdata != '0) begin
          ram_we         = 1'b1;
          ram_waddr      = pos_r;
          ram_wdata      = ram_rdata - cse_pkg::COUNT_BITS'(1);
          held_nxt       = held_r - cse_pkg::TOTAL_BITS'(1);
          scan_pos_nxt   = pos_r;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = pos_r;
          out_status_nxt = cse_pkg::ST_POPPED;
          state_nxt      = cse_pkg::S_IDLE;
        end else begin
          pos_nxt = pos_r + cse_pkg::BUCKET_BITS'(1);
        end
      end

      default: begin
        state_nxt = cse_pkg::S_IDLE;
      end
    endcase
  end

  // A scan only starts with something held, so it never runs off the top.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cse_pkg::S_SCAN) && (ram_rdata == '0) |-> (pos_r != '1))
    else $error("pop scan ran past the last bucket");

  // No result may appear while the count RAM is still being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cse_pkg::S_CLEAR) |-> !out_valid_r)
    else $error("result beat during clearing sweep");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cse_pkg::S_INS) && !ins_reject
      |=> (held_r == $past(held_r) + cse_pkg::TOTAL_BITS'(1)))
    else $error("accepted insert did not bump the held total");

  a_insert_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_req_type == cse_pkg::REQ_INSERT) |=> (state_r == cse_pkg::S_INS))
    else $error("insert did not enter the check state");

  a_pop_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cse_pkg::S_SCAN) && (ram_rdata != '0)
      |=> out_valid_r && (out_status_r == cse_pkg::ST_POPPED) && (scan_pos_r == out_value_r))
    else $error("pop hit did not return its key");

endmodule

@@ src/cse_count_ram.sv @@
module cse_count_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
